@@ rtl/seg_pkg.sv @@
// shared constants and types for the speech energy gate
`default_nettype none

package seg_pkg;

	localparam int MAX_CHUNK_SAMPLES = 1024;
	localparam int WINDOW_MAX = 32;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int THRESH_W = 16;
	localparam int CFG_K_W = 6;
	localparam int CFG_WIN_W = 6;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int MEAN_OUT_W = 16;
	localparam int SUM_W = 48;
	localparam int COUNT_W = 32;

	// level of one sample goes up to 2^15, so one more bit than the sample
	localparam int LEVEL_W = SAMPLE_W + 1;
	localparam int ACC_W = $clog2(MAX_CHUNK_SAMPLES) + SAMPLE_W;
	localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
	localparam int QUO_W = LEVEL_W;

	// window and its serial popcount, two bits a step
	localparam int WLEN_W = $clog2(WINDOW_MAX + 1);
	localparam int SEL_W = (WLEN_W > CFG_WIN_W) ? WLEN_W : CFG_WIN_W;
	localparam int POP_STEPS = (WINDOW_MAX + 1) / 2;
	localparam int POP_PAD = 2 * POP_STEPS;
	localparam int POP_W = $clog2(WINDOW_MAX + 2);
	localparam int CMP_W = (POP_W > CFG_K_W) ? POP_W : CFG_K_W;

	// serial phase covers the divide and the popcount
	localparam int SER_STEPS = (ACC_W > POP_STEPS) ? ACC_W : POP_STEPS;
	localparam int STEP_W = $clog2(SER_STEPS + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOUD_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LOUD_CHUNKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CHUNKS = 2'd2;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd600;
	localparam logic [CFG_K_W-1:0] MIN_LOUD_RESET = 6'd8;
	localparam logic [CFG_WIN_W-1:0] WINDOW_RESET = 6'd16;

	typedef struct packed {
		logic load;
		logic div_step;
		logic pop_step;
	} serial_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/speech_energy_gate.sv @@
// speech energy gate: chunk mean levels and a k-of-n loudness latch
`default_nettype none

// Samples are taken one per request. A sample without chunk_end is absorbed at once and the
// next request can follow right away. A sample with chunk_end starts a bit-serial divide of the
// chunk's level sum by its sample count, one quotient bit per cycle, while the loudness window is
// counted two bits per cycle alongside; the result is then written from the finish state, so a
// chunk-end sample holds the input through the serial and finish states, plus any time the output
// side still holds the previous result. Configuration writes are taken at any time but are meant for idle.
module speech_energy_gate (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [seg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [seg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  signed [seg_pkg::SAMPLE_W-1:0] sample,
	input  wire                                 chunk_end,
	input  wire                                 utterance_start,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [seg_pkg::MEAN_OUT_W-1:0]      chunk_mean,
	output logic                                chunk_loud,
	output logic                                heard,
	output logic                                heard_now,
	output logic [seg_pkg::MEAN_OUT_W-1:0]      peak_level,
	output logic [seg_pkg::SUM_W-1:0]           level_sum,
	output logic [seg_pkg::COUNT_W-1:0]         chunk_count
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SER = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0] state_q;
	logic [seg_pkg::STEP_W-1:0] step_q;

	logic [seg_pkg::THRESH_W-1:0]  thresh_q;
	logic [seg_pkg::CFG_K_W-1:0]   min_loud_q;
	logic [seg_pkg::CFG_WIN_W-1:0] win_cfg_q;

	logic [seg_pkg::ACC_W-1:0]      acc_q;
	logic [seg_pkg::CNT_W-1:0]      cnt_q;
	logic [seg_pkg::WINDOW_MAX-1:0] window_q;
	logic                           latch_q;
	logic [seg_pkg::QUO_W-1:0]      peak_q;
	logic [seg_pkg::SUM_W-1:0]      total_q;
	logic [seg_pkg::COUNT_W-1:0]    chunks_q;

	logic                            out_valid_q;
	logic [seg_pkg::MEAN_OUT_W-1:0]  mean_out_q;
	logic                            loud_out_q;
	logic                            heard_out_q;
	logic                            now_out_q;
	logic [seg_pkg::MEAN_OUT_W-1:0]  peak_out_q;
	logic [seg_pkg::SUM_W-1:0]       sum_out_q;
	logic [seg_pkg::COUNT_W-1:0]     count_out_q;

	seg_pkg::serial_ctrl_t ser_ctrl;

	logic                           in_take;
	logic                           out_take;
	logic                           fin_load;
	logic [seg_pkg::LEVEL_W-1:0]    level;
	logic [seg_pkg::ACC_W-1:0]      acc_base;
	logic [seg_pkg::CNT_W-1:0]      cnt_base;
	logic [seg_pkg::ACC_W-1:0]      acc_new;
	logic [seg_pkg::CNT_W-1:0]      cnt_new;
	logic [seg_pkg::WINDOW_MAX-1:0] win_base;
	logic [seg_pkg::SEL_W-1:0]      wlen;
	logic [seg_pkg::WINDOW_MAX-1:0] mask;
	logic [seg_pkg::WINDOW_MAX-1:0] pop_src;
	logic [seg_pkg::QUO_W-1:0]      mean;
	logic [seg_pkg::POP_W-1:0]      ones;
	logic                           loud;
	logic [seg_pkg::CMP_W-1:0]      ones_total;
	logic                           latch_now;
	logic [seg_pkg::SUM_W:0]        sum_wide;
	logic [seg_pkg::SUM_W-1:0]      sum_next;
	logic [seg_pkg::QUO_W-1:0]      peak_next;
	logic [seg_pkg::COUNT_W-1:0]    chunks_next;
	logic [seg_pkg::WINDOW_MAX-1:0] window_next;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign fin_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		ser_ctrl.load = in_take && chunk_end;
		ser_ctrl.div_step = (state_q == ST_SER) &&
			(step_q < seg_pkg::STEP_W'(seg_pkg::ACC_W));
		ser_ctrl.pop_step = (state_q == ST_SER) &&
			(step_q < seg_pkg::STEP_W'(seg_pkg::POP_STEPS));
	end

	// sample level and accumulation, with state cleared on utterance start
	always_comb begin
		level = sample[seg_pkg::SAMPLE_W-1] ?
			(seg_pkg::LEVEL_W'(1) << seg_pkg::SAMPLE_W) - {1'b0, sample} :
			{1'b0, sample};
		acc_base = utterance_start ? '0 : acc_q;
		cnt_base = utterance_start ? '0 : cnt_q;
		win_base = utterance_start ? '0 : window_q;
		// samples past the chunk limit are dropped
		if (cnt_base < seg_pkg::CNT_W'(seg_pkg::MAX_CHUNK_SAMPLES)) begin
			acc_new = acc_base + seg_pkg::ACC_W'(level);
			cnt_new = cnt_base + seg_pkg::CNT_W'(1);
		end else begin
			acc_new = acc_base;
			cnt_new = cnt_base;
		end
	end

	// window length clamped to one .. window max
	always_comb begin
		wlen = seg_pkg::SEL_W'(win_cfg_q);
		if (wlen == '0)
			wlen = seg_pkg::SEL_W'(1);
		if (wlen > seg_pkg::SEL_W'(seg_pkg::WINDOW_MAX))
			wlen = seg_pkg::SEL_W'(seg_pkg::WINDOW_MAX);
		for (int i = 0; i < seg_pkg::WINDOW_MAX; i++)
			mask[i] = (seg_pkg::SEL_W'(i) < wlen);
		pop_src = (win_base << 1) & mask;
	end

	seg_divider u_div (
		.clk      (clk),
		.ctrl     (ser_ctrl),
		.dividend (acc_new),
		.divisor  (cnt_new),
		.quotient (mean)
	);

	seg_popcount u_pop (
		.clk  (clk),
		.ctrl (ser_ctrl),
		.vec  (pop_src),
		.ones (ones)
	);

	// chunk close: stats, window and latch
	always_comb begin
		loud = (mean > seg_pkg::QUO_W'(thresh_q));
		ones_total = seg_pkg::CMP_W'(ones) + seg_pkg::CMP_W'(loud);
		latch_now = !latch_q && (ones_total >= seg_pkg::CMP_W'(min_loud_q));
		window_next = latch_q ? window_q : (((window_q << 1) | seg_pkg::WINDOW_MAX'(loud)) & mask);
		peak_next = (mean > peak_q) ? mean : peak_q;
		sum_wide = {1'b0, total_q} + (seg_pkg::SUM_W + 1)'(mean);
		sum_next = sum_wide[seg_pkg::SUM_W] ? '1 : sum_wide[seg_pkg::SUM_W-1:0];
		chunks_next = (chunks_q == '1) ? chunks_q : chunks_q + seg_pkg::COUNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= seg_pkg::THRESH_RESET;
			min_loud_q <= seg_pkg::MIN_LOUD_RESET;
			win_cfg_q <= seg_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				seg_pkg::REG_LOUD_THRESHOLD: thresh_q <= cfg_data[seg_pkg::THRESH_W-1:0];
				seg_pkg::REG_MIN_LOUD_CHUNKS: min_loud_q <= cfg_data[seg_pkg::CFG_K_W-1:0];
				seg_pkg::REG_WINDOW_CHUNKS: win_cfg_q <= cfg_data[seg_pkg::CFG_WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			window_q <= '0;
			latch_q <= 1'b0;
			peak_q <= '0;
			total_q <= '0;
			chunks_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (utterance_start) begin
							window_q <= '0;
							latch_q <= 1'b0;
							peak_q <= '0;
							total_q <= '0;
							chunks_q <= '0;
						end
						if (chunk_end) begin
							acc_q <= '0;
							cnt_q <= '0;
							step_q <= '0;
							state_q <= ST_SER;
						end else begin
							acc_q <= acc_new;
							cnt_q <= cnt_new;
						end
					end
				end
				ST_SER: begin
					step_q <= step_q + seg_pkg::STEP_W'(1);
					if (step_q == seg_pkg::STEP_W'(seg_pkg::SER_STEPS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_load) begin
						window_q <= window_next;
						latch_q <= latch_q || latch_now;
						peak_q <= peak_next;
						total_q <= sum_next;
						chunks_q <= chunks_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register, freed as soon as the downstream takes the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_load)
			out_valid_q <= 1'b1;
		else if (out_take)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			mean_out_q <= mean[seg_pkg::MEAN_OUT_W-1:0];
			loud_out_q <= loud;
			heard_out_q <= latch_q || latch_now;
			now_out_q <= latch_now;
			peak_out_q <= peak_next[seg_pkg::MEAN_OUT_W-1:0];
			sum_out_q <= sum_next;
			count_out_q <= chunks_next;
		end
	end

	assign out_valid = out_valid_q;
	assign chunk_mean = mean_out_q;
	assign chunk_loud = loud_out_q;
	assign heard = heard_out_q;
	assign heard_now = now_out_q;
	assign peak_level = peak_out_q;
	assign level_sum = sum_out_q;
	assign chunk_count = count_out_q;

endmodule

`default_nettype wire

@@ rtl/seg_divider.sv @@
// bit-serial restoring divider: chunk level sum by chunk sample count
`default_nettype none

module seg_divider (
	input  wire                              clk,
	input  wire seg_pkg::serial_ctrl_t       ctrl,
	input  wire  [seg_pkg::ACC_W-1:0]        dividend,
	input  wire  [seg_pkg::CNT_W-1:0]        divisor,
	output logic [seg_pkg::QUO_W-1:0]        quotient
);

	logic [seg_pkg::ACC_W-1:0] quo_q;
	logic [seg_pkg::CNT_W-1:0] rem_q;
	logic [seg_pkg::CNT_W-1:0] dvs_q;
	logic [seg_pkg::CNT_W:0]   shifted;
	logic [seg_pkg::CNT_W:0]   trial;
	logic                      fits;

	always_comb begin
		shifted = {rem_q, quo_q[seg_pkg::ACC_W-1]};
		trial = shifted - {1'b0, dvs_q};
		fits = (shifted >= {1'b0, dvs_q});
	end

	// dividend shifts out at the top while quotient bits fill in at the bottom
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (ctrl.div_step) begin
			rem_q <= fits ? trial[seg_pkg::CNT_W-1:0] : shifted[seg_pkg::CNT_W-1:0];
			quo_q <= {quo_q[seg_pkg::ACC_W-2:0], fits};
		end
	end

	assign quotient = quo_q[seg_pkg::QUO_W-1:0];

endmodule

`default_nettype wire

@@ rtl/seg_popcount.sv @@
// serial popcount of the loudness window, two bits a step
`default_nettype none

module seg_popcount (
	input  wire                                clk,
	input  wire seg_pkg::serial_ctrl_t         ctrl,
	input  wire  [seg_pkg::WINDOW_MAX-1:0]     vec,
	output logic [seg_pkg::POP_W-1:0]          ones
);

	logic [seg_pkg::POP_PAD-1:0] vec_q;
	logic [seg_pkg::POP_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			vec_q <= seg_pkg::POP_PAD'(vec);
			cnt_q <= '0;
		end else if (ctrl.pop_step) begin
			cnt_q <= cnt_q + seg_pkg::POP_W'(vec_q[0]) + seg_pkg::POP_W'(vec_q[1]);
			vec_q <= vec_q >> 2;
		end
	end

	assign ones = cnt_q;

endmodule

`default_nettype wire
